@@ rtl/assert_macros.svh @@
// Assertion macros shared by the transmit ring modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define DTR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DTR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/dtr_pkg.sv @@
// Shared codes, widths and controller/datapath interface types of the transmit ring.
`default_nettype none

package dtr_pkg;

	// Request function codes carried on s_tuser
	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_DONE  = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;

	localparam int unsigned SIZE_W   = 9;
	localparam int unsigned IN_W     = 16;
	localparam int unsigned OUT_W    = 40;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;     // request taken this cycle
		logic load_fetch; // fetch data is on the memory read port
		logic cfg_we;     // ring_size write
	} dtr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_fetch;   // presented request is a fetch
	} dtr_sts_t;

endpackage

`default_nettype wire

@@ rtl/dtr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module dtr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/dtr_ctrl.sv @@
// Handshake controller of the transmit ring: request intake, fetch wait and result valid.
`default_nettype none
`include "assert_macros.svh"

module dtr_ctrl
	import dtr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	input  wire dtr_sts_t sts,
	output dtr_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready  = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;

	assign cmd.accept     = accept;
	assign cmd.load_fetch = (state_q == ST_FETCH);
	assign cmd.cfg_we     = cfg_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.is_fetch) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load on a finished request, drop once taken
			if ((accept && !sts.is_fetch) || (state_q == ST_FETCH)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`DTR_ASSERT(ctrl_fetch_one_cycle, (state_q == ST_FETCH) |=> (state_q == ST_IDLE),
		"fetch wait lasted more than one cycle")
	`DTR_ASSERT(ctrl_fetch_enters_wait, (accept && sts.is_fetch) |=> (state_q == ST_FETCH),
		"fetch request did not enter the wait state")
	`DTR_ASSERT(ctrl_no_accept_on_stall, (m_tvalid && !m_tready) |-> !s_tready,
		"request accepted while the result register is stalled")

endmodule

`default_nettype wire

@@ rtl/dtr_datapath.sv @@
// Datapath of the transmit ring: pointers, segment bookkeeping, ring memory and result register.
`default_nettype none
`include "assert_macros.svh"

module dtr_datapath
	import dtr_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtr_cmd_t          cmd,
	output dtr_sts_t               sts,
	input  wire logic [IN_W-1:0]   s_tdata,
	input  wire logic              s_tlast,
	input  wire logic [1:0]        s_tuser,
	input  wire logic [SIZE_W-1:0] cfg_data,
	output logic      [OUT_W-1:0]  m_tdata
);

	localparam int unsigned SLOTS = (RING_DEPTH < 256) ? RING_DEPTH : 256;
	localparam int unsigned AW    = $clog2(SLOTS);
	localparam logic [SIZE_W-1:0] CAP = SIZE_W'(SLOTS);
	localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(2);

	logic [7:0]        in_byte;
	logic [7:0]        in_ridx;

	logic [AW-1:0]     wp_q, rp_q;
	logic              busy_q, req_q;
	logic [SIZE_W-1:0] seg_q, size_q;
	logic [7:0]        batch_q;
	logic              in_range_s1;

	logic [AW-1:0]     wp_d, rp_d;
	logic              busy_d, req_d;
	logic [SIZE_W-1:0] seg_d;
	logic [7:0]        batch_d;

	logic [SIZE_W-1:0] wp9, rp9, used, wp_inc9, t9, rp_done9, cfg_size;
	logic [AW-1:0]     wp_push, rp_done;
	logic              can_push, ram_we;
	logic [7:0]        ram_rdata;

	logic              r_acc, r_start;
	logic [7:0]        r_sent, r_off;
	logic [SIZE_W-1:0] r_len;

	logic              res_acc_q, res_start_q, res_req_q;
	logic [7:0]        res_sent_q, res_off_q, res_rdata_q;
	logic [SIZE_W-1:0] res_len_q;

	assign in_byte = s_tdata[7:0];
	assign in_ridx = s_tdata[15:8];
	assign sts.is_fetch = (s_tuser == FUNC_FETCH);

	// Length of the contiguous segment from rpx: up to wpx, or to the ring end on wrap
	function automatic logic [SIZE_W-1:0] seg_len(input logic [AW-1:0] wpx,
		input logic [AW-1:0] rpx, input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] w, r;
		w = SIZE_W'(wpx);
		r = SIZE_W'(rpx);
		seg_len = (w > r) ? (w - r) : (size - r);
	endfunction

	assign cfg_size = (cfg_data < MIN_SIZE) ? MIN_SIZE : ((cfg_data > CAP) ? CAP : cfg_data);

	assign wp9      = SIZE_W'(wp_q);
	assign rp9      = SIZE_W'(rp_q);
	assign used     = (wp9 >= rp9) ? (wp9 - rp9) : (size_q - rp9 + wp9);
	assign can_push = (used < (size_q - SIZE_W'(1))) && (wp9 < size_q);
	assign wp_inc9  = wp9 + SIZE_W'(1);
	assign wp_push  = (wp_inc9 >= size_q) ? '0 : wp_inc9[AW-1:0];
	// read_pos plus segment stays below twice the size: one subtract wraps it
	assign t9       = rp9 + seg_q;
	assign rp_done9 = (t9 >= size_q) ? (t9 - size_q) : t9;
	assign rp_done  = rp_done9[AW-1:0];

	always_comb begin
		wp_d    = wp_q;
		rp_d    = rp_q;
		busy_d  = busy_q;
		req_d   = req_q;
		seg_d   = seg_q;
		batch_d = batch_q;
		ram_we  = 1'b0;
		r_acc   = 1'b0;
		r_sent  = '0;
		r_start = 1'b0;
		r_off   = '0;
		r_len   = '0;
		if (cmd.accept) begin
			unique case (s_tuser)
				FUNC_PUSH: begin
					if (can_push) begin
						ram_we  = 1'b1;
						wp_d    = wp_push;
						r_acc   = 1'b1;
						batch_d = (batch_q != 8'hFF) ? (batch_q + 8'd1) : batch_q;
					end
					if (s_tlast) begin
						r_sent  = batch_d;
						batch_d = '0;
						if (!busy_q && (wp_d != rp_q)) begin
							busy_d  = 1'b1;
							seg_d   = seg_len(wp_d, rp_q, size_q);
							req_d   = 1'b1;
							r_start = 1'b1;
							r_off   = 8'(rp_q);
							r_len   = seg_d;
						end
					end
				end
				FUNC_DONE: begin
					if (busy_q) begin
						rp_d   = rp_done;
						busy_d = 1'b0;
						if (wp_q != rp_done) begin
							busy_d  = 1'b1;
							seg_d   = seg_len(wp_q, rp_done, size_q);
							req_d   = 1'b1;
							r_start = 1'b1;
							r_off   = 8'(rp_done);
							r_len   = seg_d;
						end else begin
							req_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			busy_q  <= 1'b0;
			req_q   <= 1'b0;
			seg_q   <= '0;
			batch_q <= '0;
			size_q  <= CAP;
		end else if (cmd.cfg_we) begin
			// reconfiguration empties the ring, stored bytes stay
			wp_q    <= '0;
			rp_q    <= '0;
			busy_q  <= 1'b0;
			req_q   <= 1'b0;
			seg_q   <= '0;
			batch_q <= '0;
			size_q  <= cfg_size;
		end else begin
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			busy_q  <= busy_d;
			req_q   <= req_d;
			seg_q   <= seg_d;
			batch_q <= batch_d;
		end
	end

	dtr_ram #(
		.WIDTH (8),
		.DEPTH (SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (in_byte),
		.raddr (in_ridx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Result register and fetch stage
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_range_s1 <= (SIZE_W'(in_ridx) < size_q);
		end
		if (cmd.accept && !sts.is_fetch) begin
			res_acc_q   <= r_acc;
			res_sent_q  <= r_sent;
			res_start_q <= r_start;
			res_off_q   <= r_off;
			res_len_q   <= r_len;
			res_req_q   <= req_d;
			res_rdata_q <= '0;
		end else if (cmd.load_fetch) begin
			res_acc_q   <= 1'b0;
			res_sent_q  <= '0;
			res_start_q <= 1'b0;
			res_off_q   <= '0;
			res_len_q   <= '0;
			res_req_q   <= req_q;
			res_rdata_q <= in_range_s1 ? ram_rdata : 8'd0;
		end
	end

	assign m_tdata = {4'd0, res_rdata_q, res_req_q, res_len_q, res_off_q, res_start_q,
		res_sent_q, res_acc_q};

	`DTR_ASSERT(dp_busy_has_request, busy_q |-> req_q,
		"transfer running without transmit request")
	`DTR_ASSERT(dp_wp_in_ring, (SIZE_W'(wp_q) < size_q) && (SIZE_W'(rp_q) < size_q),
		"ring pointer beyond the ring size")

endmodule

`default_nettype wire

@@ rtl/dma_tx_ring_buffer.sv @@
// Top level of the DMA transmit ring buffer: controller and datapath joined.
`default_nettype none

// Transmit byte ring for a DMA-driven serial transmitter. Each request on the
// slave stream is a push (s_tuser 0), a transfer-complete notice (1) or a fetch
// of a stored byte (2); every request yields exactly one result on the master
// stream. One slot is always kept free, so equal pointers mean empty. A push
// marked by s_tlast closes a send batch and, if no transfer runs, starts one
// over the longest contiguous segment from the read pointer. Push, complete
// and unused requests load the result register; a fetch passes a wait state for the
// registered read port of the ring memory. A new request is taken whenever no fetch
// waits and the result register is empty or being drained in the same cycle. The ring
// memory has no clearing pass: a slot that was never written reads back arbitrary
// data. A write on the cfg channel sets ring_size (clamped to 2 .. min(RING_DEPTH,
// 256)) and empties the ring; issue it only while the block is idle.
module dma_tx_ring_buffer
	import dtr_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // [7:0] data_byte, [15:8] read_index
	input  wire logic              s_tlast,  // end_of_send
	input  wire logic [1:0]        s_tuser,  // [1:0] func
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_W-1:0]  m_tdata,  // [0] accepted, [8:1] sent_count,
	                                         // [9] start_transfer, [17:10] transfer_offset,
	                                         // [26:18] transfer_length, [27] request_enable,
	                                         // [35:28] read_data, [39:36] zero
	// ring_size write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	dtr_cmd_t cmd;
	dtr_sts_t sts;

	// Sequence request intake and result valid
	dtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold pointers, segment state, ring memory and the result payload
	dtr_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

@@ tb/sv/dma_tx_ring_buffer_tb.sv @@
// Self-checking testbench for the DMA transmit ring buffer.
`timescale 1ns / 1ps

module dma_tx_ring_buffer_tb;
	import dtr_pkg::*;

	localparam int unsigned RING_DEPTH     = 256;
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	// fetch is the slowest request; this hold leaves margin beyond it
	localparam int          LATENCY_HOLD   = 4;
	localparam int          END_HOLD       = 20;
	// well above the longest gap that idle_gap gives on either side
	localparam int          WATCHDOG_LIMIT = 2000;

	// result word, first field in the lowest bits
	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] read_data;
		logic       req_en;
		logic [8:0] xfer_len;
		logic [7:0] xfer_off;
		logic       start;
		logic [7:0] sent;
		logic       accepted;
	} result_t;

	typedef struct {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       eos;
		logic [7:0] read_index;
		result_t    res;
	} request_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;
	logic              s_tlast   = 1'b0;
	logic [1:0]        s_tuser   = FUNC_PUSH;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data  = '0;

	dma_tx_ring_buffer #(
		.RING_DEPTH(RING_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	request_t pending_requests[$];
	result_t  expected_results[$];
	int       errors = 0;
	bit       steady_run = 1'b0;
	int       idle_cycles = 0;

	// Shadow of the ring, advanced as each request is queued. Requests are taken in
	// order and the size changes only while idle, so this equals the state at acceptance.
	logic [7:0]        ring_mem[256];
	bit                slot_written[256];
	logic [SIZE_W-1:0] ring_slots = 9'd256;
	int unsigned       wr_ptr = 0;
	int unsigned       rd_ptr = 0;
	bit                xfer_busy = 1'b0;
	int unsigned       seg_len = 0;
	bit                req_on = 1'b0;
	int unsigned       batch_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Usable slot count: ring_size clamped to 2 .. min(RING_DEPTH, 256).
	function automatic int unsigned ring_span();
		int unsigned cap;
		int unsigned s;
		cap = (RING_DEPTH < 256) ? RING_DEPTH : 256;
		if (cap < 2)
			cap = 2;
		s = ring_slots;
		if (s < 2)
			s = 2;
		if (s > cap)
			s = cap;
		return s;
	endfunction

	// Start the longest contiguous segment from the read pointer if idle and not empty.
	function automatic void start_segment(inout result_t r);
		int unsigned span;
		span = ring_span();
		if (xfer_busy || wr_ptr == rd_ptr)
			return;
		xfer_busy = 1'b1;
		seg_len = (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : span - rd_ptr;
		req_on = 1'b1;
		r.start = 1'b1;
		r.xfer_off = rd_ptr[7:0];
		r.xfer_len = seg_len[8:0];
	endfunction

	function automatic result_t predict_ring_result(input request_t rq);
		result_t r;
		int unsigned span;
		int unsigned used;
		int unsigned room;
		int unsigned t;
		r = '0;
		span = ring_span();
		case (rq.func)
			FUNC_PUSH: begin
				used = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : span - rd_ptr + wr_ptr;
				room = (used < span - 1) ? span - 1 - used : 0;
				// drop the byte when the ring is full
				if (room > 0 && wr_ptr < span) begin
					ring_mem[wr_ptr[7:0]] = rq.data_byte;
					slot_written[wr_ptr[7:0]] = 1'b1;
					wr_ptr = (wr_ptr + 1 >= span) ? 0 : wr_ptr + 1;
					r.accepted = 1'b1;
					if (batch_cnt < 255)
						batch_cnt++;
				end
				if (rq.eos) begin
					r.sent = batch_cnt[7:0];
					batch_cnt = 0;
					start_segment(r);
				end
			end
			FUNC_DONE: begin
				// a completion with no transfer running changes nothing
				if (xfer_busy) begin
					t = rd_ptr + seg_len;
					while (t >= span)
						t -= span;
					rd_ptr = t;
					xfer_busy = 1'b0;
					if (wr_ptr != rd_ptr)
						start_segment(r);
					else
						req_on = 1'b0;
				end
			end
			FUNC_FETCH: begin
				if (rq.read_index < span)
					r.read_data = ring_mem[rq.read_index];
			end
			default: ;
		endcase
		r.req_en = req_on;
		return r;
	endfunction

	task automatic queue_request(input logic [1:0] func, input logic [7:0] data_byte,
			input logic eos, input logic [7:0] read_index);
		request_t rq;
		rq.func = func;
		rq.data_byte = data_byte;
		rq.eos = eos;
		rq.read_index = read_index;
		rq.res = predict_ring_result(rq);
		pending_requests.push_back(rq);
	endtask

	// Choose a fetch slot that is either beyond the ring or already written.
	function automatic bit pick_fetch_slot(inout logic [7:0] idx);
		int unsigned span;
		int unsigned s;
		span = ring_span();
		if (span < 256 && $urandom_range(0, 4) == 0) begin
			idx = 8'($urandom_range(span, 255));
			return 1'b1;
		end
		for (int k = 0; k < 8; k++) begin
			s = $urandom_range(0, span - 1);
			if (slot_written[s]) begin
				idx = 8'(s);
				return 1'b1;
			end
		end
		if (span < 256) begin
			idx = 8'($urandom_range(span, 255));
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mostly pushes closed by end marks, completions while a transfer runs, and
	// fetches; a few spurious completions and unused requests as noise.
	task automatic queue_random_traffic(input int count, input int eos_pct, input int done_pct);
		int unsigned sel;
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic [7:0]  idx;
		logic        eos;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			data_byte = 8'($urandom);
			idx = 8'($urandom);
			eos = ($urandom_range(0, 3) == 0);
			if (sel < done_pct && (xfer_busy || $urandom_range(0, 9) == 0))
				func = FUNC_DONE;
			else if (sel >= done_pct && sel < done_pct + 15 && pick_fetch_slot(idx))
				func = FUNC_FETCH;
			else if (sel >= done_pct + 15 && sel < done_pct + 18)
				func = FUNC_UNUSED;
			else begin
				func = FUNC_PUSH;
				eos = ($urandom_range(0, 99) < eos_pct);
			end
			queue_request(func, data_byte, eos, idx);
		end
	endtask

	function automatic int idle_gap();
		int unsigned r;
		if (steady_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Hold the sender until every queued request is taken and its result checked.
	task automatic wait_for_results();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	// Write ring_size once idle; the block empties the ring, so do the same here.
	task automatic write_ring_size(input logic [SIZE_W-1:0] value);
		repeat (LATENCY_HOLD) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		ring_slots = value;
		wr_ptr = 0;
		rd_ptr = 0;
		xfer_busy = 1'b0;
		seg_len = 0;
		req_on = 1'b0;
		batch_cnt = 0;
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endfunction

	// Request driver: present the next queued request after a random gap.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		bit              holding;
		static request_t in_flight;
		static int       send_gap = 0;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= FUNC_PUSH;
			send_gap = 0;
		end else begin
			holding = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(in_flight.res);
				holding = 1'b0;
				send_gap = idle_gap();
			end
			if (!holding) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_requests.size() > 0) begin
					in_flight = pending_requests.pop_front();
					s_tdata <= {in_flight.read_index, in_flight.data_byte};
					s_tlast <= in_flight.eos;
					s_tuser <= in_flight.func;
					holding = 1'b1;
				end
			end
			s_tvalid <= holding;
		end
	end

	// Result monitor: stall at random, compare each result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : check_results
		result_t   got;
		result_t   want;
		static int stall_left = 0;
		static int phase_cycles = 0;
		if (!arst_n) begin
			m_tready <= 1'b0;
			steady_run <= 1'b0;
			stall_left = 0;
			phase_cycles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected none, actual 0x%0h",
						$time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("sent_count", want.sent, got.sent);
					check_field("start_transfer", want.start, got.start);
					check_field("transfer_offset", want.xfer_off, got.xfer_off);
					check_field("transfer_length", want.xfer_len, got.xfer_len);
					check_field("request_enable", want.req_en, got.req_en);
					check_field("read_data", want.read_data, got.read_data);
					check_field("tdata padding", want.pad, got.pad);
				end
			end
			// switch now and then to a stretch with no idling on either side
			phase_cycles++;
			if (phase_cycles == 200) begin
				phase_cycles = 0;
				steady_run <= ($urandom_range(0, 3) == 0);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_gap();
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-size ring after reset: unused request, spurious completion, first
		// segment, end mark while busy, chained segments, request dropped when empty.
		queue_request(FUNC_UNUSED, 8'h3C, 1'b1, 8'hC3);
		queue_request(FUNC_DONE, 8'hFF, 1'b1, 8'hFF);
		queue_request(FUNC_PUSH, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_PUSH, 8'hFF, 1'b1, 8'hFF);
		queue_request(FUNC_FETCH, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_FETCH, 8'hFF, 1'b0, 8'h01);
		queue_request(FUNC_PUSH, 8'hA5, 1'b1, 8'h00);
		queue_request(FUNC_DONE, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_DONE, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_PUSH, 8'h5A, 1'b1, 8'h80);
		queue_request(FUNC_DONE, 8'h00, 1'b0, 8'h00);
		wait_for_results();

		// Smallest ring: full ring drops, fetch beyond the ring, segment at the wrap.
		write_ring_size(9'd0);
		queue_request(FUNC_PUSH, 8'h11, 1'b0, 8'h00);
		queue_request(FUNC_PUSH, 8'h22, 1'b0, 8'h00);
		queue_request(FUNC_PUSH, 8'h33, 1'b1, 8'h00);
		queue_request(FUNC_FETCH, 8'h00, 1'b0, 8'hFF);
		queue_request(FUNC_FETCH, 8'h00, 1'b0, 8'h02);
		queue_request(FUNC_FETCH, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_DONE, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_PUSH, 8'h44, 1'b1, 8'h00);
		queue_request(FUNC_DONE, 8'h00, 1'b0, 8'h00);
		queue_request(FUNC_FETCH, 8'h00, 1'b1, 8'h01);
		wait_for_results();

		queue_random_traffic(60, 30, 30);
		wait_for_results();

		write_ring_size(9'd5);
		queue_random_traffic(60, 25, 25);
		wait_for_results();
		queue_random_traffic(60, 25, 25);
		wait_for_results();

		// One long batch on the largest ring, drained by completions, so that the
		// accepted count saturates before the closing end mark.
		write_ring_size(9'd511);
		queue_request(FUNC_PUSH, 8'($urandom), 1'b1, 8'($urandom));
		queue_random_traffic(400, 0, 6);
		queue_request(FUNC_PUSH, 8'($urandom), 1'b1, 8'($urandom));
		wait_for_results();

		write_ring_size(9'd3);
		queue_random_traffic(80, 30, 30);
		wait_for_results();

		write_ring_size(9'd255);
		queue_random_traffic(100, 20, 20);
		wait_for_results();

		write_ring_size(9'd1);
		queue_random_traffic(40, 30, 30);
		wait_for_results();

		write_ring_size(9'($urandom_range(2, 300)));
		queue_random_traffic(60, 20, 25);
		wait_for_results();

		repeat (END_HOLD) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
